// File: hw/rtl/ipv4fhg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4fhg_pkg
// Shared types and constants of the IPv4 fragment header generator.
// ----------------------------------------------------------------------------
package ipv4fhg_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDRESS         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_TO_LIVE          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAGMENT_PAYLOAD_SIZE = 2'd2;

  localparam logic [7:0]  TTL_RESET       = 8'd64;
  localparam logic [10:0] FRAG_SIZE_RESET = 11'd1480;
  localparam logic [10:0] FRAG_MIN        = 11'd1024;
  localparam logic [10:0] FRAG_MAX        = 11'd1480;
  localparam logic [15:0] HDR_BYTES       = 16'd20;
  localparam logic [15:0] VER_IHL_TOS     = 16'h4500;

  // Header words run through the adder in this order; the checksum word is zero.
  localparam logic [3:0] WORD_VER      = 4'd0;
  localparam logic [3:0] WORD_TLEN     = 4'd1;
  localparam logic [3:0] WORD_ID       = 4'd2;
  localparam logic [3:0] WORD_FLAGSOFF = 4'd3;
  localparam logic [3:0] WORD_TTLPROTO = 4'd4;
  localparam logic [3:0] WORD_SRC_HI   = 4'd5;
  localparam logic [3:0] WORD_SRC_LO   = 4'd6;
  localparam logic [3:0] WORD_DST_HI   = 4'd7;
  localparam logic [3:0] WORD_DST_LO   = 4'd8;

  typedef struct packed {
    logic [15:0] payload_length;
    logic [31:0] destination_address;
    logic [7:0]  protocol;
  } in_t;

  typedef struct packed {
    logic [15:0] identification;
    logic [15:0] total_length;
    logic [12:0] offset_units;
    logic        more_fragments;
    logic [15:0] header_checksum;
    logic [15:0] payload_start;
    logic [10:0] fragment_length;
    logic        last;
  } out_t;

endpackage
`default_nettype wire

// File: hw/rtl/ipv4_fragment_header_generator.sv
// Sequence: after a request is accepted, and after each header taken that is
// not the last, a setup state (CALC) and nine passes of the shared 16-bit
// end-around-carry adder build the next fragment header.
// Operation: one datagram at a time, input ready only while idle. Reset:
// synchronous active-low rst_n clears the sequencer and the identification
// counter and loads the register defaults.
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_fragment_header_generator
// Splits a datagram descriptor into fragments and builds each header's
// per-fragment fields and checksum with one shared one's complement adder.
// ----------------------------------------------------------------------------
module ipv4_fragment_header_generator (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire [ipv4fhg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [ipv4fhg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire ipv4fhg_pkg::in_t                 in_data,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output ipv4fhg_pkg::out_t                     out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [31:0] local_address_r;
  logic [7:0]  ttl_r;
  logic [10:0] frag_size_r;

  logic [1:0]  state_r, state_nxt;
  logic [15:0] ident_r, ident_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] rest_r, rest_nxt;
  logic [15:0] start_r, start_nxt;
  logic [10:0] frag_r, frag_nxt;
  logic [10:0] flen_r, flen_nxt;
  logic        mf_r, mf_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [3:0]  widx_r, widx_nxt;
  logic [15:0] sum_r, sum_nxt;

  logic [10:0] frag_masked;
  logic [10:0] frag_clamped;
  logic [15:0] tlen;
  logic [15:0] word;
  logic [16:0] add_raw;
  logic [15:0] add_fold;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_address_r <= '0;
      ttl_r           <= ipv4fhg_pkg::TTL_RESET;
      frag_size_r     <= ipv4fhg_pkg::FRAG_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ipv4fhg_pkg::CFG_LOCAL_ADDRESS:         local_address_r <= cfg_data;
        ipv4fhg_pkg::CFG_TIME_TO_LIVE:          ttl_r <= cfg_data[7:0];
        ipv4fhg_pkg::CFG_FRAGMENT_PAYLOAD_SIZE: frag_size_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    frag_masked = {frag_size_r[10:3], 3'b000};
    if (frag_masked < ipv4fhg_pkg::FRAG_MIN) begin
      frag_clamped = ipv4fhg_pkg::FRAG_MIN;
    end else if (frag_masked > ipv4fhg_pkg::FRAG_MAX) begin
      frag_clamped = ipv4fhg_pkg::FRAG_MAX;
    end else begin
      frag_clamped = frag_masked;
    end
  end

  assign tlen = {5'd0, flen_r} + ipv4fhg_pkg::HDR_BYTES;

  // Header word feeding the shared adder
  always_comb begin
    case (widx_r)
      ipv4fhg_pkg::WORD_VER:      word = ipv4fhg_pkg::VER_IHL_TOS;
      ipv4fhg_pkg::WORD_TLEN:     word = tlen;
      ipv4fhg_pkg::WORD_ID:       word = id_r;
      ipv4fhg_pkg::WORD_FLAGSOFF: word = {2'b00, mf_r, start_r[15:3]};
      ipv4fhg_pkg::WORD_TTLPROTO: word = {ttl_r, proto_r};
      ipv4fhg_pkg::WORD_SRC_HI:   word = local_address_r[31:16];
      ipv4fhg_pkg::WORD_SRC_LO:   word = local_address_r[15:0];
      ipv4fhg_pkg::WORD_DST_HI:   word = dst_r[31:16];
      ipv4fhg_pkg::WORD_DST_LO:   word = dst_r[15:0];
      default:                    word = '0;
    endcase
  end

  // Fold the carry back in: one's complement add
  assign add_raw  = {1'b0, sum_r} + {1'b0, word};
  assign add_fold = add_raw[15:0] + {15'd0, add_raw[16]};

  always_comb begin
    state_nxt = state_r;
    ident_nxt = ident_r;
    id_nxt    = id_r;
    rest_nxt  = rest_r;
    start_nxt = start_r;
    frag_nxt  = frag_r;
    flen_nxt  = flen_r;
    mf_nxt    = mf_r;
    dst_nxt   = dst_r;
    proto_nxt = proto_r;
    widx_nxt  = widx_r;
    sum_nxt   = sum_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          id_nxt    = ident_r;
          ident_nxt = ident_r + 16'd1;
          rest_nxt  = in_data.payload_length;
          dst_nxt   = in_data.destination_address;
          proto_nxt = in_data.protocol;
          frag_nxt  = frag_clamped;
          start_nxt = '0;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (rest_r > {5'd0, frag_r}) begin
          flen_nxt = frag_r;
          mf_nxt   = 1'b1;
        end else begin
          flen_nxt = rest_r[10:0];
          mf_nxt   = 1'b0;
        end
        sum_nxt   = '0;
        widx_nxt  = ipv4fhg_pkg::WORD_VER;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        sum_nxt  = add_fold;
        widx_nxt = widx_r + 4'd1;
        if (widx_r == ipv4fhg_pkg::WORD_DST_LO) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          // Advance to the next slice, or drop back to idle after the last
          start_nxt = start_r + {5'd0, flen_r};
          rest_nxt  = rest_r - {5'd0, flen_r};
          state_nxt = mf_r ? ST_CALC : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ident_r <= '0;
    end else begin
      state_r <= state_nxt;
      ident_r <= ident_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    rest_r  <= rest_nxt;
    start_r <= start_nxt;
    frag_r  <= frag_nxt;
    flen_r  <= flen_nxt;
    mf_r    <= mf_nxt;
    dst_r   <= dst_nxt;
    proto_r <= proto_nxt;
    widx_r  <= widx_nxt;
    sum_r   <= sum_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    out_data.identification  = id_r;
    out_data.total_length    = tlen;
    out_data.offset_units    = start_r[15:3];
    out_data.more_fragments  = mf_r;
    out_data.header_checksum = ~sum_r;
    out_data.payload_start   = start_r;
    out_data.fragment_length = flen_r;
    out_data.last            = ~mf_r;
  end

endmodule
`default_nettype wire
